// ----- sv/triple_store_pattern_query_unit_macros.svh -----
// Assertion macros for the triple store pattern query unit.
// Used by the top level only; needs nothing else.
`ifndef TRIPLE_STORE_PATTERN_QUERY_UNIT_MACROS_SVH
`define TRIPLE_STORE_PATTERN_QUERY_UNIT_MACROS_SVH

// same-cycle implication
`define TSPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tspq_pkg.sv -----
// Shared types and constants of the triple store pattern query unit.
// No dependencies.
package tspq_pkg;

   localparam int unsigned CAPACITY_DEF   = 4096;
   localparam int unsigned JOIN_SLOTS_DEF = 1024;
   localparam int unsigned MAX_HITS_DEF   = 64;

   localparam int ID_W      = 32;
   localparam int LIMIT_W   = 7;
   localparam int ACT_W     = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [ID_W-1:0] TYPE_PRED_RST    = 32'd1;
   localparam logic [ID_W-1:0] KNOWS_PRED_RST   = 32'd3;
   localparam logic [ID_W-1:0] PERSON_CLASS_RST = 32'd100;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD       = 3'd0,
      ACT_TYPE      = 3'd1,
      ACT_SUBJ_PRED = 3'd2,
      ACT_JOIN      = 3'd3,
      ACT_SOCIAL    = 3'd4
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TYPE_PRED    = 2'd0,
      CSR_KNOWS_PRED   = 2'd1,
      CSR_PERSON_CLASS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_MATCH = 3'd0,
      MODE_BUILD = 3'd1,
      MODE_PROBE = 3'd2,
      MODE_OUTER = 3'd3,
      MODE_INNER = 3'd4
   } mode_type;

   typedef struct packed {
      logic     start;
      logic     add;
      logic     init;
      logic     init_outer;
      logic     clear;
      logic     run;
      logic     oi_inc;
      logic     soc_push;
      logic     finish;
      mode_type mode;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic clr_done;
      logic out_free;
      logic hold;
      logic knows;
      logic social_end;
   } status_type;

endpackage

// ----- sv/triple_store_pattern_query_unit.sv -----
// Top level of the triple store pattern query unit.
// Depends on tspq_pkg, tspq_ctrl, tspq_dp and the assertion macro header.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   action, ids, second predicate, limit
//   rsp      out        rsp_valid/rsp_stall   hit flag, value, count, add flag, last
//   csr      in         csr_we (no wait)      csr_index, csr_wdata
//
// One item at a time. Add stores the triple if there is room; a type or subject-predicate
// query is one scan of the store. Join: a clearing pass over all JOIN_SLOTS table slots, then
// two scans of the store (build, then probe). Social: one outer step per stored triple, plus
// a scan of the store for each knows link; every scan uses the single read port of the store.
// Reset is synchronous; the store needs no clearing pass. A stalled result holds the
// scan as soon as a second match waits behind it.
`include "triple_store_pattern_query_unit_macros.svh"

module triple_store_pattern_query_unit #(
   parameter int unsigned CAPACITY   = tspq_pkg::CAPACITY_DEF,
   parameter int unsigned JOIN_SLOTS = tspq_pkg::JOIN_SLOTS_DEF,
   parameter int unsigned MAX_HITS   = tspq_pkg::MAX_HITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tspq_pkg::ACT_W-1:0]        req_action,
   input  logic [tspq_pkg::ID_W-1:0]         req_subject_id,
   input  logic [tspq_pkg::ID_W-1:0]         req_predicate_id,
   input  logic [tspq_pkg::ID_W-1:0]         req_object_id,
   input  logic [tspq_pkg::ID_W-1:0]         req_second_predicate_id,
   input  logic [tspq_pkg::LIMIT_W-1:0]      req_result_limit,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit_valid,
   output logic [tspq_pkg::ID_W-1:0]         rsp_hit_value,
   output logic [tspq_pkg::LIMIT_W-1:0]      rsp_hit_count,
   output logic                              rsp_add_accepted,
   output logic                              rsp_last_item,
   input  logic                              csr_we,
   input  logic [tspq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tspq_pkg::ID_W-1:0]         csr_wdata
);

   tspq_pkg::cmd_type    cmd;
   tspq_pkg::status_type status;

   tspq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   tspq_dp #(
      .CAPACITY   (CAPACITY),
      .JOIN_SLOTS (JOIN_SLOTS),
      .MAX_HITS   (MAX_HITS)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .req_action              (req_action),
      .req_subject_id          (req_subject_id),
      .req_predicate_id        (req_predicate_id),
      .req_object_id           (req_object_id),
      .req_second_predicate_id (req_second_predicate_id),
      .req_result_limit        (req_result_limit),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .cmd                     (cmd),
      .status                  (status),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_hit_valid           (rsp_hit_valid),
      .rsp_hit_value           (rsp_hit_value),
      .rsp_hit_count           (rsp_hit_count),
      .rsp_add_accepted        (rsp_add_accepted),
      .rsp_last_item           (rsp_last_item)
   );

   `TSPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted item did not make the unit busy")
   `TSPQ_ASSERT_SAME(a_load_needs_room, clock, reset, cmd.add || cmd.finish, status.out_free, "result register loaded while occupied")
   `TSPQ_ASSERT_SAME(a_hit_has_count, clock, reset, rsp_valid && rsp_hit_valid, rsp_hit_count != 7'd0, "hit item with zero count")
   `TSPQ_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_valid && !rsp_hit_valid, rsp_last_item, "item without hit is not final")

endmodule

// ----- sv/tspq_ctrl.sv -----
// Sequencer of the triple store pattern query unit.
// Depends on tspq_pkg; drives commands to tspq_dp and reads its status.
module tspq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [tspq_pkg::ACT_W-1:0]    req_action,
   output logic                          req_stall,
   input  tspq_pkg::status_type          status,
   output tspq_pkg::cmd_type             cmd
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_ADD   = 11'b00000000010,
      ST_SCAN  = 11'b00000000100,
      ST_CLEAR = 11'b00000001000,
      ST_BUILD = 11'b00000010000,
      ST_PROBE = 11'b00000100000,
      ST_NEXT  = 11'b00001000000,
      ST_OUTER = 11'b00010000000,
      ST_INNER = 11'b00100000000,
      ST_HIT   = 11'b01000000000,
      ST_FIN   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mode = tspq_pkg::MODE_MATCH;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               case (tspq_pkg::action_type'(req_action))
                  tspq_pkg::ACT_ADD: state_in = ST_ADD;
                  tspq_pkg::ACT_TYPE, tspq_pkg::ACT_SUBJ_PRED: begin
                     cmd.init = 1'b1;
                     state_in = ST_SCAN;
                  end
                  tspq_pkg::ACT_JOIN:   state_in = ST_CLEAR;
                  tspq_pkg::ACT_SOCIAL: state_in = ST_NEXT;
                  default:              state_in = ST_FIN;
               endcase
            end
         end
         ST_ADD: begin
            if (status.out_free) begin
               cmd.add  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.run = 1'b1;
            if (status.scan_done) state_in = ST_FIN;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_done) begin
               cmd.init = 1'b1;
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            cmd.run  = 1'b1;
            cmd.mode = tspq_pkg::MODE_BUILD;
            if (status.scan_done) begin
               cmd.init = 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.run  = 1'b1;
            cmd.mode = tspq_pkg::MODE_PROBE;
            if (status.scan_done) state_in = ST_FIN;
         end
         ST_NEXT: begin
            if (status.social_end) begin
               state_in = ST_FIN;
            end else begin
               cmd.init       = 1'b1;
               cmd.init_outer = 1'b1;
               state_in       = ST_OUTER;
            end
         end
         ST_OUTER: begin
            cmd.run  = 1'b1;
            cmd.mode = tspq_pkg::MODE_OUTER;
            if (status.scan_done) begin
               if (status.knows) begin
                  cmd.init = 1'b1;
                  state_in = ST_INNER;
               end else begin
                  cmd.oi_inc = 1'b1;
                  state_in   = ST_NEXT;
               end
            end
         end
         ST_INNER: begin
            cmd.run  = 1'b1;
            cmd.mode = tspq_pkg::MODE_INNER;
            if (status.scan_done) state_in = ST_HIT;
         end
         ST_HIT: begin
            cmd.soc_push = 1'b1;
            if (!status.hold) begin
               cmd.oi_inc = 1'b1;
               state_in   = ST_NEXT;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/tspq_dp.sv -----
// Datapath of the triple store pattern query unit: triple store, join table,
// scan pipeline, hit buffer and result register. Depends on tspq_pkg.
module tspq_dp #(
   parameter int unsigned CAPACITY   = tspq_pkg::CAPACITY_DEF,
   parameter int unsigned JOIN_SLOTS = tspq_pkg::JOIN_SLOTS_DEF,
   parameter int unsigned MAX_HITS   = tspq_pkg::MAX_HITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tspq_pkg::ACT_W-1:0]        req_action,
   input  logic [tspq_pkg::ID_W-1:0]         req_subject_id,
   input  logic [tspq_pkg::ID_W-1:0]         req_predicate_id,
   input  logic [tspq_pkg::ID_W-1:0]         req_object_id,
   input  logic [tspq_pkg::ID_W-1:0]         req_second_predicate_id,
   input  logic [tspq_pkg::LIMIT_W-1:0]      req_result_limit,
   input  logic                              csr_we,
   input  logic [tspq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tspq_pkg::ID_W-1:0]         csr_wdata,
   input  tspq_pkg::cmd_type                 cmd,
   output tspq_pkg::status_type              status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic                              rsp_hit_valid,
   output logic [tspq_pkg::ID_W-1:0]         rsp_hit_value,
   output logic [tspq_pkg::LIMIT_W-1:0]      rsp_hit_count,
   output logic                              rsp_add_accepted,
   output logic                              rsp_last_item
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SW  = $clog2(JOIN_SLOTS);
   localparam int RW  = SW + 1;
   localparam int RSH = 32 + SW;
   localparam logic [32:0]   RECIP = 33'((66'd1 << RSH) / JOIN_SLOTS);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [6:0]    MAXH  = 7'(MAX_HITS);
   localparam logic [31:0]   JS_W  = 32'(JOIN_SLOTS);
   localparam logic [RW-1:0] JS_R  = RW'(JOIN_SLOTS);
   localparam logic [SW-1:0] CLR_LAST = SW'(JOIN_SLOTS - 1);

   typedef struct packed {
      logic        vld;
      logic [31:0] s;
      logic [31:0] o;
      logic [31:0] val;
      logic        f_hit;
      logic        f_slot;
      logic        f_knows;
      logic        f_pa;
      logic        f_pb;
   } pipe_type;

   logic [31:0] subj_mem [CAPACITY];
   logic [31:0] pred_mem [CAPACITY];
   logic [31:0] obj_mem  [CAPACITY];
   logic [32:0] join_mem [JOIN_SLOTS];

   logic [31:0] type_pred_ff, knows_pred_ff, person_ff;
   tspq_pkg::action_type action_ff;
   logic [31:0] subj_ff, pred_ff, obj_ff, pred2_ff;
   logic [6:0]  eff_ff, n_ff;
   logic [CW-1:0] count_ff, rd_addr_ff, end_ff, oi_ff;
   logic        v1_ff;
   logic [31:0] s1_ff, p1_ff, o1_ff;
   pipe_type    st2_ff, st3_ff, st4_ff, st2_in;
   logic [64:0] m2_ff;
   logic [RW-1:0] r3_ff;
   logic [32:0] js_rd_ff;
   logic [31:0] a_ff, b_ff;
   logic        knows_ff, fa_ff, fb_ff;
   logic [SW-1:0] clr_ff;
   logic        pend_vld_ff;
   logic [31:0] pend_val_ff;
   logic [6:0]  pend_cnt_ff;
   logic        out_vld_ff, out_hv_ff, out_acc_ff, out_last_ff;
   logic [31:0] out_val_ff;
   logic [6:0]  out_cnt_ff;

   logic        out_free, hold, adv, lim_reached, stop_lim, more, issue, pipe_busy;
   logic        room, build_we, probe_hit, fin_hit, soc_hit, push;
   logic [31:0] push_val, q_w, qj, r_full;
   logic [64:0] m2_in;
   logic [RW-1:0] r3_in, slot_r;
   logic [SW-1:0] slot_idx;
   logic [6:0]  lim_in;

   assign out_free    = !out_vld_ff || !rsp_stall;
   assign hold        = pend_vld_ff && !out_free;
   assign adv         = !hold;
   assign lim_reached = (n_ff >= eff_ff);
   assign stop_lim    = ((cmd.mode == tspq_pkg::MODE_MATCH) ||
                         (cmd.mode == tspq_pkg::MODE_PROBE)) && lim_reached;
   assign more        = (rd_addr_ff < end_ff) && !stop_lim;
   assign issue       = cmd.run && adv && more;
   assign pipe_busy   = v1_ff || st2_ff.vld || st3_ff.vld || st4_ff.vld;
   assign room        = (count_ff < CAP_C);
   assign lim_in      = (req_result_limit > MAXH) ? MAXH : req_result_limit;

   assign status.scan_done  = !more && !pipe_busy;
   assign status.clr_done   = (clr_ff == CLR_LAST);
   assign status.out_free   = out_free;
   assign status.hold       = hold;
   assign status.knows      = knows_ff;
   assign status.social_end = (oi_ff >= count_ff) || lim_reached;

   always_comb begin
      st2_in.vld     = v1_ff;
      st2_in.s       = s1_ff;
      st2_in.o       = o1_ff;
      st2_in.val     = (action_ff == tspq_pkg::ACT_SUBJ_PRED) ? o1_ff : s1_ff;
      st2_in.f_hit   = (action_ff == tspq_pkg::ACT_SUBJ_PRED) ?
                       (s1_ff == subj_ff && p1_ff == pred_ff) :
                       (p1_ff == type_pred_ff && o1_ff == obj_ff);
      st2_in.f_slot  = (cmd.mode == tspq_pkg::MODE_PROBE) ? (p1_ff == pred2_ff) :
                                                            (p1_ff == pred_ff);
      st2_in.f_knows = (p1_ff == knows_pred_ff);
      st2_in.f_pa    = (p1_ff == type_pred_ff) && (o1_ff == person_ff) && (s1_ff == a_ff);
      st2_in.f_pb    = (p1_ff == type_pred_ff) && (o1_ff == person_ff) && (s1_ff == b_ff);
   end

   assign m2_in    = 65'(s1_ff) * 65'(RECIP);
   assign q_w      = 32'(m2_ff >> RSH);
   assign qj       = q_w * JS_W;
   assign r_full   = st2_ff.s - qj;
   assign r3_in    = r_full[RW-1:0];
   assign slot_r   = (r3_ff >= JS_R) ? (r3_ff - JS_R) : r3_ff;
   assign slot_idx = slot_r[SW-1:0];
   assign build_we = adv && st3_ff.vld && st3_ff.f_slot &&
                     (cmd.mode == tspq_pkg::MODE_BUILD);

   assign probe_hit = st4_ff.f_slot && js_rd_ff[32] && (js_rd_ff[31:0] == st4_ff.s);
   assign fin_hit   = st4_ff.vld && !lim_reached &&
                      (((cmd.mode == tspq_pkg::MODE_MATCH) && st4_ff.f_hit) ||
                       ((cmd.mode == tspq_pkg::MODE_PROBE) && probe_hit));
   assign soc_hit   = cmd.soc_push && fa_ff && fb_ff && !lim_reached;
   assign push      = adv && (fin_hit || soc_hit);
   assign push_val  = soc_hit ? a_ff : st4_ff.val;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_pred_ff  <= tspq_pkg::TYPE_PRED_RST;
         knows_pred_ff <= tspq_pkg::KNOWS_PRED_RST;
         person_ff     <= tspq_pkg::PERSON_CLASS_RST;
      end else if (csr_we) begin
         case (tspq_pkg::csr_index_type'(csr_index))
            tspq_pkg::CSR_TYPE_PRED:    type_pred_ff  <= csr_wdata;
            tspq_pkg::CSR_KNOWS_PRED:   knows_pred_ff <= csr_wdata;
            tspq_pkg::CSR_PERSON_CLASS: person_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         action_ff <= tspq_pkg::action_type'(req_action);
         subj_ff   <= req_subject_id;
         pred_ff   <= req_predicate_id;
         obj_ff    <= req_object_id;
         pred2_ff  <= req_second_predicate_id;
         eff_ff    <= lim_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && room) begin
         subj_mem[count_ff[AW-1:0]] <= subj_ff;
         pred_mem[count_ff[AW-1:0]] <= pred_ff;
         obj_mem[count_ff[AW-1:0]]  <= obj_ff;
      end
      if (issue) begin
         s1_ff <= subj_mem[rd_addr_ff[AW-1:0]];
         p1_ff <= pred_mem[rd_addr_ff[AW-1:0]];
         o1_ff <= obj_mem[rd_addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         join_mem[clr_ff] <= '0;
      end else if (build_we) begin
         join_mem[slot_idx] <= {1'b1, st3_ff.s};
      end
      if (adv) begin
         js_rd_ff <= join_mem[slot_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_addr_ff <= '0;
         end_ff     <= '0;
         oi_ff      <= '0;
         n_ff       <= '0;
         v1_ff      <= 1'b0;
         st2_ff     <= '0;
         st3_ff     <= '0;
         st4_ff     <= '0;
         knows_ff   <= 1'b0;
         fa_ff      <= 1'b0;
         fb_ff      <= 1'b0;
         clr_ff     <= '0;
      end else begin
         if (cmd.add && room) count_ff <= count_ff + 1'b1;
         if (cmd.start) begin
            oi_ff  <= '0;
            n_ff   <= '0;
            clr_ff <= '0;
         end else begin
            if (cmd.oi_inc) oi_ff <= oi_ff + 1'b1;
            if (push) n_ff <= n_ff + 1'b1;
            if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.init) begin
            rd_addr_ff <= cmd.init_outer ? oi_ff : '0;
            end_ff     <= cmd.init_outer ? (oi_ff + 1'b1) : count_ff;
            v1_ff      <= 1'b0;
            st2_ff.vld <= 1'b0;
            st3_ff.vld <= 1'b0;
            st4_ff.vld <= 1'b0;
            if (cmd.init_outer) begin
               knows_ff <= 1'b0;
            end else begin
               fa_ff <= 1'b0;
               fb_ff <= 1'b0;
            end
         end else begin
            if (issue) rd_addr_ff <= rd_addr_ff + 1'b1;
            if (adv) begin
               v1_ff  <= issue;
               st2_ff <= st2_in;
               st3_ff <= st2_ff;
               st4_ff <= st3_ff;
               if (st4_ff.vld && cmd.mode == tspq_pkg::MODE_OUTER) begin
                  knows_ff <= st4_ff.f_knows;
               end
               if (st4_ff.vld && cmd.mode == tspq_pkg::MODE_INNER) begin
                  fa_ff <= fa_ff | st4_ff.f_pa;
                  fb_ff <= fb_ff | st4_ff.f_pb;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_ff <= m2_in;
         r3_ff <= r3_in;
         if (st4_ff.vld && cmd.mode == tspq_pkg::MODE_OUTER) begin
            a_ff <= st4_ff.s;
            b_ff <= st4_ff.o;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (cmd.start || cmd.finish) begin
         pend_vld_ff <= 1'b0;
      end else if (push) begin
         pend_vld_ff <= 1'b1;
      end
      if (push) begin
         pend_val_ff <= push_val;
         pend_cnt_ff <= n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         if (out_vld_ff && !rsp_stall) out_vld_ff <= 1'b0;
         if (cmd.add) begin
            out_vld_ff  <= 1'b1;
            out_hv_ff   <= 1'b0;
            out_val_ff  <= '0;
            out_cnt_ff  <= '0;
            out_acc_ff  <= room;
            out_last_ff <= 1'b1;
         end else if (cmd.finish) begin
            out_vld_ff  <= 1'b1;
            out_hv_ff   <= pend_vld_ff;
            out_val_ff  <= pend_vld_ff ? pend_val_ff : '0;
            out_cnt_ff  <= pend_vld_ff ? pend_cnt_ff : '0;
            out_acc_ff  <= 1'b0;
            out_last_ff <= 1'b1;
         end else if (push && pend_vld_ff) begin
            out_vld_ff  <= 1'b1;
            out_hv_ff   <= 1'b1;
            out_val_ff  <= pend_val_ff;
            out_cnt_ff  <= pend_cnt_ff;
            out_acc_ff  <= 1'b0;
            out_last_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_hit_valid    = out_hv_ff;
   assign rsp_hit_value    = out_val_ff;
   assign rsp_hit_count    = out_cnt_ff;
   assign rsp_add_accepted = out_acc_ff;
   assign rsp_last_item    = out_last_ff;

endmodule

// ----- tb/triple_store_pattern_query_unit_test.sv -----
// Self-checking bench for the triple store pattern query unit: a directed table, then
// random adds and queries, each checked against an in-bench predictor of the store.
// Depends on tspq_pkg and the triple_store_pattern_query_unit top level.
module triple_store_pattern_query_unit_test;

   localparam int CAP = 4096;
   localparam int SLOTS = 1024;
   localparam int HITS = 64;
   localparam longint CYCLE_LIMIT = 64'd20000000;

   typedef struct packed {
      logic [tspq_pkg::ACT_W-1:0]   action;
      logic [tspq_pkg::ID_W-1:0]    subj;
      logic [tspq_pkg::ID_W-1:0]    pred;
      logic [tspq_pkg::ID_W-1:0]    obj;
      logic [tspq_pkg::ID_W-1:0]    pred2;
      logic [tspq_pkg::LIMIT_W-1:0] limit;
   } query_item_type;

   typedef struct packed {
      logic                         hit;
      logic [tspq_pkg::ID_W-1:0]    value;
      logic [tspq_pkg::LIMIT_W-1:0] count;
      logic                         accepted;
      logic                         last;
   } answer_type;

   typedef struct packed {
      query_item_type q;
      logic           fixed;
      answer_type     a;
   } table_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [tspq_pkg::ACT_W-1:0] req_action = '0;
   logic [tspq_pkg::ID_W-1:0] req_subject_id = '0, req_predicate_id = '0;
   logic [tspq_pkg::ID_W-1:0] req_object_id = '0, req_second_predicate_id = '0;
   logic [tspq_pkg::LIMIT_W-1:0] req_result_limit = '0;
   logic rsp_valid, rsp_stall = 0;
   logic rsp_hit_valid, rsp_add_accepted, rsp_last_item;
   logic [tspq_pkg::ID_W-1:0] rsp_hit_value;
   logic [tspq_pkg::LIMIT_W-1:0] rsp_hit_count;
   logic csr_we = 0;
   logic [tspq_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tspq_pkg::ID_W-1:0] csr_wdata = '0;

   triple_store_pattern_query_unit uut (.*);

   initial forever #5 clock = ~clock;

   logic [tspq_pkg::ID_W-1:0] st_s [CAP], st_p [CAP], st_o [CAP];
   int unsigned st_n;
   logic [tspq_pkg::ID_W-1:0] type_pred_id, knows_id, person_id;
   answer_type pending [$];
   answer_type first_answer;
   int errors = 0;
   longint cycles = 0;
   bit hold_off = 0;

   function automatic answer_type hit_of(logic [tspq_pkg::ID_W-1:0] v, int n);
      answer_type a;
      a = '{1'b1, v, n[tspq_pkg::LIMIT_W-1:0], 1'b0, 1'b0};
      return a;
   endfunction

   function automatic bit has_person(logic [tspq_pkg::ID_W-1:0] who);
      for (int j = 0; j < st_n; j++)
         if (st_s[j] == who && st_p[j] == type_pred_id && st_o[j] == person_id) return 1;
      return 0;
   endfunction

   task automatic predict_answers(query_item_type q);
      logic [tspq_pkg::ID_W-1:0] slot_v [SLOTS];
      bit slot_u [SLOTS];
      answer_type got [$];
      int lim;
      int h;
      lim = (q.limit > HITS) ? HITS : q.limit;
      if (q.action == tspq_pkg::ACT_ADD) begin
         bit ok;
         ok = 0;
         if (st_n < CAP) begin
            st_s[st_n] = q.subj; st_p[st_n] = q.pred; st_o[st_n] = q.obj;
            st_n++; ok = 1;
         end
         first_answer = '{1'b0, 32'd0, 7'd0, ok, 1'b1};
         pending.push_back(first_answer);
         return;
      end
      if (q.action == tspq_pkg::ACT_JOIN) begin
         for (int k = 0; k < SLOTS; k++) slot_u[k] = 0;
         for (int i = 0; i < st_n; i++)
            if (st_p[i] == q.pred) begin
               h = st_s[i] % SLOTS; slot_v[h] = st_s[i]; slot_u[h] = 1;
            end
      end
      for (int i = 0; i < st_n && got.size() < lim; i++) begin
         case (q.action)
            tspq_pkg::ACT_TYPE: if (st_p[i] == type_pred_id && st_o[i] == q.obj)
               got.push_back(hit_of(st_s[i], got.size() + 1));
            tspq_pkg::ACT_SUBJ_PRED: if (st_s[i] == q.subj && st_p[i] == q.pred)
               got.push_back(hit_of(st_o[i], got.size() + 1));
            tspq_pkg::ACT_JOIN: if (st_p[i] == q.pred2) begin
               h = st_s[i] % SLOTS;
               for (int p = 0; p < 3; p++)
                  if (slot_u[(h + p) % SLOTS] && slot_v[(h + p) % SLOTS] == st_s[i]) begin
                     got.push_back(hit_of(st_s[i], got.size() + 1));
                     break;
                  end
            end
            tspq_pkg::ACT_SOCIAL: if (st_p[i] == knows_id && has_person(st_s[i]) &&
                                      has_person(st_o[i]))
               got.push_back(hit_of(st_s[i], got.size() + 1));
            default: ;
         endcase
      end
      if (got.size() == 0) got.push_back('{1'b0, 32'd0, 7'd0, 1'b0, 1'b0});
      got[got.size() - 1].last = 1;
      first_answer = got[0];
      foreach (got[k]) pending.push_back(got[k]);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            $error("result with nothing expected: value %h", rsp_hit_value);
            errors++;
         end else begin
            answer_type e;
            e = pending.pop_front();
            if (rsp_hit_valid !== e.hit) begin
               $error("hit_valid exp %0d got %0d", e.hit, rsp_hit_valid); errors++;
            end
            if (rsp_hit_value !== e.value) begin
               $error("hit_value exp %h got %h", e.value, rsp_hit_value); errors++;
            end
            if (rsp_hit_count !== e.count) begin
               $error("hit_count exp %0d got %0d", e.count, rsp_hit_count); errors++;
            end
            if (rsp_add_accepted !== e.accepted) begin
               $error("add_accepted exp %0d got %0d", e.accepted, rsp_add_accepted);
               errors++;
            end
            if (rsp_last_item !== e.last) begin
               $error("last_item exp %0d got %0d", e.last, rsp_last_item); errors++;
            end
         end
      end
   end

   // receiver stall pattern: random stalls with periodic quiet periods, forced on during hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if (cycles % 700 < 150) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   task automatic send(query_item_type q);
      req_valid <= 1;
      req_action <= q.action; req_subject_id <= q.subj; req_predicate_id <= q.pred;
      req_object_id <= q.obj; req_second_predicate_id <= q.pred2;
      req_result_limit <= q.limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_answers(q);
   endtask

   task automatic gap();
      int g;
      g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(tspq_pkg::csr_index_type idx, logic [tspq_pkg::ID_W-1:0] v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         tspq_pkg::CSR_TYPE_PRED: type_pred_id = v;
         tspq_pkg::CSR_KNOWS_PRED: knows_id = v;
         default: person_id = v;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [tspq_pkg::ID_W-1:0] pick_id(int narrow);
      case ($urandom_range(0, 9))
         0: return 32'hFFFF_FFFF;
         1: return 32'd0;
         2: return $urandom();
         default: return $urandom_range(0, narrow);
      endcase
   endfunction

   function automatic query_item_type rand_item(bit allow_bad);
      query_item_type q;
      int r;
      r = $urandom_range(0, 99);
      q.action = (r < 55) ? tspq_pkg::ACT_ADD : (r < 67) ? tspq_pkg::ACT_TYPE :
                 (r < 79) ? tspq_pkg::ACT_SUBJ_PRED : (r < 89) ? tspq_pkg::ACT_JOIN :
                 (r < 97) ? tspq_pkg::ACT_SOCIAL : 3'(allow_bad ? 5 + r % 3 : 1);
      q.subj = pick_id(6);
      q.pred = ($urandom_range(0, 2) == 0) ? type_pred_id :
               ($urandom_range(0, 2) == 0) ? knows_id : pick_id(5);
      q.obj = ($urandom_range(0, 2) == 0) ? person_id : pick_id(6);
      if (q.pred == knows_id && q.action == tspq_pkg::ACT_ADD) q.obj = pick_id(6);
      q.pred2 = pick_id(5);
      q.limit = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
                7'($urandom_range(1, 8));
      return q;
   endfunction

   localparam int ROWS = 20;
   table_row_type rows [ROWS] = '{
      '{'{tspq_pkg::ACT_TYPE, 32'd0, 32'd0, 32'd100, 32'd0, 7'd64}, 1,
        '{0, 0, 0, 0, 1}},
      '{'{tspq_pkg::ACT_ADD, 32'd5, 32'd1, 32'd100, 32'd0, 7'd1}, 1, '{0, 0, 0, 1, 1}},
      '{'{tspq_pkg::ACT_ADD, 32'd6, 32'd1, 32'd100, 32'd0, 7'd1}, 1, '{0, 0, 0, 1, 1}},
      '{'{tspq_pkg::ACT_ADD, 32'd5, 32'd3, 32'd6, 32'd0, 7'd1}, 1, '{0, 0, 0, 1, 1}},
      '{'{tspq_pkg::ACT_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          7'h7F}, 1, '{0, 0, 0, 1, 1}},
      '{'{tspq_pkg::ACT_ADD, 32'd0, 32'd7, 32'd0, 32'd0, 7'd1}, 1, '{0, 0, 0, 1, 1}},
      '{'{tspq_pkg::ACT_ADD, 32'd1029, 32'd7, 32'd9, 32'd0, 7'd1}, 1, '{0, 0, 0, 1, 1}},
      '{'{tspq_pkg::ACT_ADD, 32'd1029, 32'd8, 32'd9, 32'd0, 7'd1}, 1, '{0, 0, 0, 1, 1}},
      '{'{tspq_pkg::ACT_TYPE, 32'd0, 32'd0, 32'd100, 32'd0, 7'd64}, 0, '0},
      '{'{tspq_pkg::ACT_TYPE, 32'd0, 32'd0, 32'd100, 32'd0, 7'd1}, 0, '0},
      '{'{tspq_pkg::ACT_TYPE, 32'd0, 32'd0, 32'd100, 32'd0, 7'd0}, 1, '{0, 0, 0, 0, 1}},
      '{'{tspq_pkg::ACT_TYPE, 32'd0, 32'd0, 32'd100, 32'd0, 7'h7F}, 0, '0},
      '{'{tspq_pkg::ACT_SUBJ_PRED, 32'd5, 32'd3, 32'd0, 32'd0, 7'd5}, 0, '0},
      '{'{tspq_pkg::ACT_SUBJ_PRED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0, 7'd5}, 0,
        '0},
      '{'{tspq_pkg::ACT_JOIN, 32'd0, 32'd7, 32'd0, 32'd8, 7'd9}, 0, '0},
      '{'{tspq_pkg::ACT_JOIN, 32'd0, 32'd9, 32'd0, 32'd7, 7'd9}, 1, '{0, 0, 0, 0, 1}},
      '{'{tspq_pkg::ACT_SOCIAL, 32'd0, 32'd0, 32'd0, 32'd0, 7'd64}, 0, '0},
      '{'{3'd5, 32'd5, 32'd1, 32'd100, 32'd0, 7'd9}, 1, '{0, 0, 0, 0, 1}},
      '{'{3'd6, 32'd0, 32'd0, 32'd0, 32'd0, 7'd9}, 1, '{0, 0, 0, 0, 1}},
      '{'{3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd9}, 1,
        '{0, 0, 0, 0, 1}}
   };

   initial begin
      query_item_type q;
      st_n = 0;
      type_pred_id = tspq_pkg::TYPE_PRED_RST;
      knows_id = tspq_pkg::KNOWS_PRED_RST;
      person_id = tspq_pkg::PERSON_CLASS_RST;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int r = 0; r < ROWS; r++) begin
         send(rows[r].q);
         if (rows[r].fixed && first_answer != rows[r].a) begin
            $error("table row %0d: predictor disagrees with typed answer", r);
            errors++;
         end
         gap();
      end
      // long receiver hold-off while the sender keeps offering
      drain();
      hold_off = 1;
      fork
         begin repeat (400) @(posedge clock); hold_off = 0; end
         for (int k = 0; k < 8; k++) send(rand_item(0));
      join
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_csr(tspq_pkg::CSR_TYPE_PRED, 32'd2);
                     write_csr(tspq_pkg::CSR_KNOWS_PRED, 32'd4);
                     write_csr(tspq_pkg::CSR_PERSON_CLASS, 32'd0); end
            1: begin write_csr(tspq_pkg::CSR_TYPE_PRED, 32'hFFFFFFFF);
                     write_csr(tspq_pkg::CSR_KNOWS_PRED, 32'hFFFFFFFF);
                     write_csr(tspq_pkg::CSR_PERSON_CLASS, 32'hFFFFFFFF); end
            2: begin write_csr(tspq_pkg::CSR_TYPE_PRED, 32'd0);
                     write_csr(tspq_pkg::CSR_KNOWS_PRED, 32'd0);
                     write_csr(tspq_pkg::CSR_PERSON_CLASS, 32'd0); end
            default: begin write_csr(tspq_pkg::CSR_TYPE_PRED, $urandom());
                     write_csr(tspq_pkg::CSR_KNOWS_PRED, $urandom_range(0, 5));
                     write_csr(tspq_pkg::CSR_PERSON_CLASS, $urandom_range(0, 6)); end
         endcase
         for (int k = 0; k < 26; k++) begin
            q = rand_item(1);
            send(q);
            gap();
         end
         drain();
      end
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+sv
sv/tspq_pkg.sv
sv/tspq_ctrl.sv
sv/tspq_dp.sv
sv/triple_store_pattern_query_unit.sv
tb/triple_store_pattern_query_unit_test.sv
